### rtl/bf5_pkg.sv
// Shared constants, types and helpers for the 5x5 box filter.
package bf5_pkg;

  localparam int WIN_DIM       = 5;
  localparam int DEF_MAX_WIDTH = 512;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = WIN_DIM;
  localparam int RESET_WIDTH   = 512;
  localparam int RESET_HEIGHT  = 512;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 9;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int WCFG_W    = 10;
  localparam int HEIGHT_W  = 13;
  localparam int IDX_W     = 3;
  localparam int SLOTS     = WIN_DIM - 1;
  localparam int WORD_W    = SLOTS * PIX_W;
  localparam int ROWSUM_W  = 11;
  localparam int ACC_W     = 13;

  // floor(s / 25) == (s * RECIP_25) >> RECIP_SHIFT for all s <= 25 * 255
  localparam int RECIP_W     = 16;
  localparam int RECIP_25    = 41944;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = ACC_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic accept;    // latch pixel, start line read
    logic update;    // shift window, write line store, advance position
    logic acc_step;  // add one window row to the sum
    logic mult;      // scale sum by reciprocal of 25
    logic load;      // move result into output register, step to next result
  } bf5_cmd_t;

  typedef struct packed {
    logic emit;      // current pixel produces results
    logic m_last;    // last window row of this result
    logic res_last;  // last result for this pixel
    logic out_free;  // output register can take a result
  } bf5_sts_t;

  // clamp a window index to the bottom/right edge
  function automatic logic [IDX_W-1:0] lim(input logic [IDX_W:0] v);
    if (v > (IDX_W+1)'(WIN_DIM - 1)) begin
      return IDX_W'(WIN_DIM - 1);
    end
    return v[IDX_W-1:0];
  endfunction

endpackage

### rtl/bf5_line_mem.sv
// Line store: one word per column, one byte lane per buffered row.
module bf5_line_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bf5_datapath.sv
// Datapath: position counters, line store, 5x5 window, row-serial sum and scaling.
module bf5_datapath #(
  parameter int MAX_WIDTH = bf5_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bf5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf5_pkg::CFG_W-1:0]       cfg_data,
  input  logic [bf5_pkg::PIX_W-1:0]       pixel,
  input  bf5_pkg::bf5_cmd_t               cmd,
  output bf5_pkg::bf5_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bf5_pkg::PIX_W-1:0]       average,
  output logic [bf5_pkg::ROW_W-1:0]       out_row,
  output logic [bf5_pkg::OUT_COL_W-1:0]   out_col,
  output logic                            last_of_run
);
  import bf5_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    col_count;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [PIX_W-1:0]    cur_pix;
  logic                last_row_f;
  logic                last_col_f;

  logic [PIX_W-1:0]    win [0:WIN_DIM-1][0:WIN_DIM-1];
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   wr_word;

  logic [IDX_W-1:0]    a_idx;
  logic [IDX_W-1:0]    b_idx;
  logic [IDX_W-1:0]    m_idx;
  logic [ROWSUM_W-1:0] row_sum;
  logic [ACC_W-1:0]    acc;
  logic [PROD_W-1:0]   prod;

  logic [WCFG_W-1:0]   w_raw;
  logic [HEIGHT_W-1:0] h_raw;
  logic                a_last;
  logic                b_last;
  logic                out_free;

  bf5_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (cmd.accept),
    .rd_addr (col_count),
    .rd_data (rd_word),
    .wr_en   (cmd.update),
    .wr_addr (cur_col),
    .wr_data (wr_word)
  );

  // replace the lane of the current row slot with the new pixel
  always_comb begin
    wr_word = rd_word;
    wr_word[cur_row[1:0]*PIX_W +: PIX_W] = cur_pix;
  end

  assign w_raw = cfg_data[WCFG_W-1:0];
  assign h_raw = cfg_data[HEIGHT_W-1:0];

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(RESET_WIDTH < MAX_WIDTH ? RESET_WIDTH : MAX_WIDTH);
      image_height <= HEIGHT_W'(RESET_HEIGHT);
      row_count    <= '0;
      col_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (32'(w_raw) < 32'(MIN_DIM)) begin
            image_width <= WIDTH_W'(MIN_DIM);
          end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
            image_width <= WIDTH_W'(MAX_WIDTH);
          end else begin
            image_width <= WIDTH_W'(w_raw);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (32'(h_raw) < 32'(MIN_DIM)) begin
            image_height <= HEIGHT_W'(MIN_DIM);
          end else if (32'(h_raw) > 32'(MAX_HEIGHT)) begin
            image_height <= HEIGHT_W'(MAX_HEIGHT);
          end else begin
            image_height <= h_raw;
          end
        end
      endcase
      row_count <= '0;
      col_count <= '0;
    end else if (cmd.update) begin
      if ((WIDTH_W'(cur_col) + WIDTH_W'(1)) >= image_width) begin
        col_count <= '0;
        if ((HEIGHT_W'(cur_row) + HEIGHT_W'(1)) >= image_height) begin
          row_count <= '0;
        end else begin
          row_count <= cur_row + ROW_W'(1);
        end
      end else begin
        col_count <= cur_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pix <= pixel;
      cur_row <= row_count;
      cur_col <= col_count;
    end
    if (cmd.update) begin
      last_row_f <= (HEIGHT_W'(cur_row) == (image_height - HEIGHT_W'(1)));
      last_col_f <= (WIDTH_W'(cur_col) == (image_width - WIDTH_W'(1)));
      for (int i = 0; i < WIN_DIM; i++) begin
        for (int j = 0; j < WIN_DIM - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        win[i][WIN_DIM-1] <= rd_word[2'(cur_row[1:0] + 2'(i))*PIX_W +: PIX_W];
      end
      win[WIN_DIM-1][WIN_DIM-1] <= cur_pix;
    end
  end

  // one window row per cycle, indices clamped at the bottom/right edge
  always_comb begin
    logic [IDX_W-1:0] rs;
    logic [IDX_W-1:0] cs;
    rs      = lim({1'b0, a_idx} + {1'b0, m_idx});
    row_sum = '0;
    for (int n = 0; n < WIN_DIM; n++) begin
      cs      = lim({1'b0, b_idx} + (IDX_W+1)'(n));
      row_sum = row_sum + ROWSUM_W'(win[rs][cs]);
    end
  end

  assign a_last = !last_row_f || (a_idx == IDX_W'(WIN_DIM - 1));
  assign b_last = !last_col_f || (b_idx == IDX_W'(WIN_DIM - 1));

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      a_idx <= '0;
      b_idx <= '0;
      m_idx <= '0;
    end else if (cmd.acc_step) begin
      acc   <= ((m_idx == '0) ? '0 : acc) + ACC_W'(row_sum);
      m_idx <= m_idx + IDX_W'(1);
    end else if (cmd.load) begin
      m_idx <= '0;
      if (b_last) begin
        b_idx <= '0;
        a_idx <= a_idx + IDX_W'(1);
      end else begin
        b_idx <= b_idx + IDX_W'(1);
      end
    end
    if (cmd.mult) begin
      prod <= PROD_W'(acc) * PROD_W'(RECIP_25);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      average     <= prod[RECIP_SHIFT +: PIX_W];
      out_row     <= cur_row - ROW_W'(WIN_DIM - 1) + ROW_W'(a_idx);
      out_col     <= OUT_COL_W'(32'(cur_col) - 32'(WIN_DIM - 1) + 32'(b_idx));
      last_of_run <= a_last && b_last;
    end
  end

  assign sts.emit     = (cur_row >= ROW_W'(WIN_DIM - 1)) &&
                        (32'(cur_col) >= 32'(WIN_DIM - 1));
  assign sts.m_last   = (m_idx == IDX_W'(WIN_DIM - 1));
  assign sts.res_last = a_last && b_last;
  assign sts.out_free = out_free;

endmodule

### rtl/bf5_ctrl.sv
// Controller: sequences line read, window update and per-result sum/scale/output.
module bf5_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bf5_pkg::bf5_sts_t sts,
  output bf5_pkg::bf5_cmd_t cmd
);
  import bf5_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_ACCUM,
    S_MULT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.emit ? S_ACCUM : S_IDLE;
      end
      S_ACCUM: begin
        cmd.acc_step = 1'b1;
        if (sts.m_last) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.res_last ? S_IDLE : S_ACCUM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/box_filter_5x5_replicate_unit.sv
// 5x5 box filter top: pixel in, averaged pixels with coordinates out.
// A pixel that produces no result is taken with a line store read, then an update.
// A pixel that produces results is read and updated the same way; each result then sums the window one
// row per cycle, scales by 1/25 in a multiply step, then loads the output register once it is free.
// The output register lets the next pixel be taken while the last result waits.
// Reset: position to row 0, column 0, size 512 x 512 (width capped at MAX_WIDTH); line store and window not cleared.
module box_filter_5x5_replicate_unit #(
  parameter int MAX_WIDTH = bf5_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bf5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf5_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bf5_pkg::PIX_W-1:0]       pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bf5_pkg::PIX_W-1:0]       average,
  output logic [bf5_pkg::ROW_W-1:0]       out_row,
  output logic [bf5_pkg::OUT_COL_W-1:0]   out_col,
  output logic                            last_of_run
);
  import bf5_pkg::*;

  bf5_cmd_t cmd;
  bf5_sts_t sts;

  bf5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bf5_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average     (average),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the 5x5 replicate-edge box filter unit.
module testbench;
  import bf5_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 200;
  localparam int N_DIRECTED    = 12;

  typedef enum logic [2:0] {
    STEP_WIDTH, STEP_HEIGHT, STEP_HOLD, STEP_FLAT, STEP_NOISE
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [CFG_W-1:0] value;
    int               count;
    int               fixed_avg;  // -1: use the predicted mean
  } dir_step_t;

  typedef struct packed {
    logic [PIX_W-1:0]     average;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } mean_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel     = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     average;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 last_of_run;

  // predictor copy of the filter state
  logic [PIX_W-1:0] line_mem [SLOTS][MAX_W];
  logic [PIX_W-1:0] win [WIN_DIM][WIN_DIM];
  int geo_w   = RESET_WIDTH;
  int geo_h   = RESET_HEIGHT;
  int pos_row = 0;
  int pos_col = 0;

  mean_result_t expected_means[$];
  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_request  = 0;
  int stall_left     = 0;

  dir_step_t directed_steps [N_DIRECTED] = '{
    '{STEP_FLAT,   13'd90,    3,     -1},   // 512x512 after reset: nothing comes out yet
    '{STEP_HEIGHT, 13'd5,     0,     -1},
    '{STEP_WIDTH,  13'd0,     0,     -1},   // clamps to 5
    '{STEP_HOLD,   13'd0,     300,   -1},   // receiver holds off while pixels keep coming
    '{STEP_FLAT,   13'd255,   28,    255},  // white 5x5, then the start of the next image
    '{STEP_WIDTH,  13'h1C06,  0,     -1},   // bits above the register dropped: 6
    '{STEP_HEIGHT, 13'h1FFF,  0,     -1},   // clamps to 4096
    '{STEP_NOISE,  13'd0,     4,     -1},
    '{STEP_WIDTH,  13'h3FF,   0,     -1},   // clamps to 512
    '{STEP_NOISE,  13'd0,     4,     -1},
    '{STEP_HEIGHT, 13'd5,     0,     -1},
    '{STEP_WIDTH,  13'd5,     0,     -1}
  };

  box_filter_5x5_replicate_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average     (average),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clip_idx(int v);
    return (v > WIN_DIM - 1) ? WIN_DIM - 1 : v;
  endfunction

  function automatic int clamp_dim(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] window_mean(int a, int b);
    int sum;
    sum = 0;
    for (int m = 0; m < WIN_DIM; m++)
      for (int n = 0; n < WIN_DIM; n++)
        sum += win[clip_idx(a + m)][clip_idx(b + n)];
    return PIX_W'(sum / (WIN_DIM * WIN_DIM));
  endfunction

  function automatic logic [PIX_W-1:0] noise_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // shift the window, update the line store, queue the means this pixel releases
  task automatic predict_pixel(input logic [PIX_W-1:0] p, input int fixed_avg);
    int r, c, na, nb;
    mean_result_t res;
    r = pos_row;
    c = pos_col;
    for (int i = 0; i < WIN_DIM; i++)
      for (int j = 0; j < WIN_DIM - 1; j++)
        win[i][j] = win[i][j + 1];
    for (int i = 0; i < SLOTS; i++)
      win[i][WIN_DIM - 1] = line_mem[(r + i) % SLOTS][c];
    win[WIN_DIM - 1][WIN_DIM - 1] = p;
    line_mem[r % SLOTS][c] = p;
    if (r >= WIN_DIM - 1 && c >= WIN_DIM - 1) begin
      // bottom row / right column flush the remaining edge outputs
      na = (r == geo_h - 1) ? WIN_DIM : 1;
      nb = (c == geo_w - 1) ? WIN_DIM : 1;
      for (int a = 0; a < na; a++)
        for (int b = 0; b < nb; b++) begin
          res.average = (fixed_avg >= 0) ? PIX_W'(fixed_avg) : window_mean(a, b);
          res.row     = ROW_W'(r - (WIN_DIM - 1) + a);
          res.col     = OUT_COL_W'(c - (WIN_DIM - 1) + b);
          res.last    = (a == na - 1) && (b == nb - 1);
          expected_means.push_back(res);
        end
    end
    if (c + 1 >= geo_w) begin
      pos_col = 0;
      pos_row = (r + 1 >= geo_h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p, input int fixed_avg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (!in_ready);
    predict_pixel(p, fixed_avg);
  endtask

  task automatic wait_results_done();
    do @(posedge clk); while (expected_means.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    wait_results_done();
    // a pixel with no output may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) geo_w = clamp_dim(int'(val[WCFG_W-1:0]), MIN_DIM, MAX_W);
    else geo_h = clamp_dim(int'(val), MIN_DIM, MAX_HEIGHT);
    pos_row = 0;
    pos_col = 0;
  endtask

  task automatic run_random_phase(input int target);
    int sent, n;
    logic [CFG_W-1:0] wraw, hraw;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(3) != 0) begin
        wraw = CFG_W'($urandom_range(6, 5));
        hraw = CFG_W'($urandom_range(6, 5));
        case ($urandom_range(5))
          0: wraw = CFG_W'($urandom_range(4));  // below range
          1: wraw = wraw | 13'h1C00;             // junk above the width field
          2: hraw = CFG_W'($urandom_range(4));
          default: ;
        endcase
        if ($urandom_range(1)) begin
          write_reg(REG_IMAGE_WIDTH, wraw);
          write_reg(REG_IMAGE_HEIGHT, hraw);
        end else begin
          write_reg(REG_IMAGE_HEIGHT, hraw);
          write_reg(REG_IMAGE_WIDTH, wraw);
        end
      end
      n = geo_w * geo_h;
      if ($urandom_range(3) == 0) n = $urandom_range(n - 1, 1);  // broken image
      repeat (n) send_pixel(noise_pixel(), -1);
      sent += n;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    mean_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got avg %0d row %0d",
                 $time, average, out_row);
        $display("%0t:   col %0d last %0d", $time, out_col, last_of_run);
      end else begin
        want = expected_means.pop_front();
        compare_field("average", want.average, average);
        compare_field("out_row", want.row, out_row);
        compare_field("out_col", want.col, out_col);
        compare_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int s = 0; s < SLOTS; s++)
      for (int x = 0; x < MAX_W; x++)
        line_mem[s][x] = '0;
    for (int i = 0; i < WIN_DIM; i++)
      for (int j = 0; j < WIN_DIM; j++)
        win[i][j] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        STEP_WIDTH:  write_reg(REG_IMAGE_WIDTH, directed_steps[i].value);
        STEP_HEIGHT: write_reg(REG_IMAGE_HEIGHT, directed_steps[i].value);
        STEP_HOLD:   stall_request = directed_steps[i].count;
        STEP_FLAT:
          repeat (directed_steps[i].count)
            send_pixel(directed_steps[i].value[PIX_W-1:0], directed_steps[i].fixed_avg);
        default:
          repeat (directed_steps[i].count)
            send_pixel(noise_pixel(), directed_steps[i].fixed_avg);
      endcase
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      run_random_phase(20);
    end

    in_valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
